FILE: design/etrb_pkg.sv
`default_nettype none

package etrb_pkg;

  // number of comparator timers
  localparam int NUM_TIMERS = 3;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TICK_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_LEGACY_CAP    = 2'd1;
  localparam logic [1:0] CFG_ROUTE_MASK    = 2'd2;

  // word map
  localparam logic [9:0] W_CAP_LO   = 10'h000;
  localparam logic [9:0] W_CAP_HI   = 10'h001;
  localparam logic [9:0] W_CFG_LO   = 10'h004;
  localparam logic [9:0] W_ISR_LO   = 10'h008;
  localparam logic [9:0] W_CNT_LO   = 10'h03C;
  localparam logic [9:0] W_CNT_HI   = 10'h03D;

  // timer block: words 64 + 8n, sub-word in the low three bits
  localparam logic [3:0] W_TMR_PAGE = 4'h1;
  localparam logic [2:0] SUB_CONF   = 3'd0;
  localparam logic [2:0] SUB_ROUTE  = 3'd1;
  localparam logic [2:0] SUB_CMP_LO = 3'd2;
  localparam logic [2:0] SUB_CMP_HI = 3'd3;

  // capability constants
  localparam logic [7:0] CAP_REVISION = 8'h01;

  // reset value of the tick period configuration register
  localparam logic [26:0] TICK_PERIOD_RESET = 27'd69841279;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  word_index;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  timer_irq;
  } result_t;

endpackage

`default_nettype wire

FILE: design/event_timer_register_block.sv
`default_nettype none

// channel   dir  handshake                    word
// item      in   item_valid / item_stall      item_t: command, word_index, write_data
// result    out  result_valid / result_stall  result_t: read_data, timer_irq
// cfg       in   cfg_valid / cfg_ready        cfg_index, cfg_data
//
// one item per cycle while item_stall is low: the whole access or tick is
// resolved in the accept cycle (one 64-bit increment and NUM_TIMERS 64-bit
// equality compares) and its result is registered in the output register.
// a skid register holds one more result while the output is held, so input
// keeps flowing after result_stall rises; item_stall is high only while it is full.
// rst is synchronous and returns all timer state to its reset values.
module event_timer_register_block
  import etrb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output      logic        item_stall,
  input  wire item_t       item,
  output      logic        result_valid,
  input  wire logic        result_stall,
  output      result_t     result,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration registers
  logic [26:0] tick_period_fs;
  logic        legacy_route_capable;
  logic [31:0] timer_route_mask;

  // timer state
  logic [63:0]           main_count;
  logic                  global_enable;
  logic                  legacy_route_on;
  logic [NUM_TIMERS-1:0] level_status;
  logic [NUM_TIMERS-1:0] t_level;
  logic [NUM_TIMERS-1:0] t_enable;
  logic [4:0]            t_route [NUM_TIMERS];
  logic [63:0]           compare_value [NUM_TIMERS];

  // next values
  logic [63:0]           main_count_next;
  logic                  global_enable_next;
  logic                  legacy_route_on_next;
  logic [NUM_TIMERS-1:0] level_status_next;
  logic [NUM_TIMERS-1:0] t_level_next;
  logic [NUM_TIMERS-1:0] t_enable_next;
  logic [4:0]            t_route_next [NUM_TIMERS];
  logic [63:0]           compare_value_next [NUM_TIMERS];

  logic [63:0]           count_inc;
  logic [NUM_TIMERS-1:0] pulse;
  logic [NUM_TIMERS-1:0] tmr_hit;
  logic                  tmr_page;
  logic [2:0]            sub;
  logic [31:0]           rd;
  result_t               res;

  // output and skid registers
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic accept;
  logic take;

  assign cfg_ready    = 1'b1;
  assign item_stall   = skid_valid;
  assign accept       = item_valid && !skid_valid;
  assign take         = out_valid && !result_stall;
  assign result_valid = out_valid;
  assign result       = out_data;

  // timer word decode
  assign tmr_page  = (item.word_index[9:6] == W_TMR_PAGE);
  assign sub       = item.word_index[2:0];
  assign count_inc = main_count + 64'd1;

  always_comb begin
    for (int n = 0; n < NUM_TIMERS; n++) begin
      tmr_hit[n] = tmr_page && (item.word_index[5:3] == 3'(n));
    end
  end

  // read mux
  always_comb begin
    rd = 32'd0;
    priority if (item.word_index == W_CAP_LO) begin
      rd = {16'd0, legacy_route_capable, 1'b0, 1'b1, 5'(NUM_TIMERS - 1), CAP_REVISION};
    end else if (item.word_index == W_CAP_HI) begin
      rd = {5'd0, tick_period_fs};
    end else if (item.word_index == W_CFG_LO) begin
      rd = {30'd0, legacy_route_on, global_enable};
    end else if (item.word_index == W_ISR_LO) begin
      rd = 32'(level_status);
    end else if (item.word_index == W_CNT_LO) begin
      rd = main_count[31:0];
    end else if (item.word_index == W_CNT_HI) begin
      rd = main_count[63:32];
    end else begin
      for (int n = 0; n < NUM_TIMERS; n++) begin
        if (tmr_hit[n]) begin
          unique case (sub)
            SUB_CONF:   rd = {18'd0, t_route[n], 3'd0, 1'b1, 2'd0, t_enable[n], t_level[n],
                              1'b0};
            SUB_ROUTE:  rd = timer_route_mask;
            SUB_CMP_LO: rd = compare_value[n][31:0];
            SUB_CMP_HI: rd = compare_value[n][63:32];
            default:    rd = 32'd0;
          endcase
        end
      end
    end
  end

  // state update for the accepted item
  always_comb begin
    main_count_next      = main_count;
    global_enable_next   = global_enable;
    legacy_route_on_next = legacy_route_on;
    level_status_next    = level_status;
    t_level_next         = t_level;
    t_enable_next        = t_enable;
    t_route_next         = t_route;
    compare_value_next   = compare_value;
    pulse                = '0;

    unique case (item.command)
      CMD_TICK: begin
        if (global_enable) begin
          main_count_next = count_inc;
          for (int n = 0; n < NUM_TIMERS; n++) begin
            if ((compare_value[n] == count_inc) && t_enable[n]) begin
              if (t_level[n]) begin
                level_status_next[n] = 1'b1;
              end else begin
                pulse[n] = 1'b1;
              end
            end
          end
        end
      end
      CMD_WRITE: begin
        priority if (item.word_index == W_CFG_LO) begin
          global_enable_next   = item.write_data[0];
          legacy_route_on_next = item.write_data[1];
        end else if (item.word_index == W_ISR_LO) begin
          level_status_next = level_status & ~item.write_data[NUM_TIMERS-1:0];
        end else if (item.word_index == W_CNT_LO) begin
          main_count_next[31:0] = item.write_data;
        end else if (item.word_index == W_CNT_HI) begin
          main_count_next[63:32] = item.write_data;
        end else begin
          for (int n = 0; n < NUM_TIMERS; n++) begin
            if (tmr_hit[n]) begin
              unique case (sub)
                SUB_CONF: begin
                  t_level_next[n]  = item.write_data[1];
                  t_enable_next[n] = item.write_data[2];
                  t_route_next[n]  = item.write_data[13:9];
                end
                SUB_CMP_LO: compare_value_next[n][31:0]  = item.write_data;
                SUB_CMP_HI: compare_value_next[n][63:32] = item.write_data;
                default: ;
              endcase
            end
          end
        end
      end
      default: ;
    endcase

    res.read_data = (item.command == CMD_READ) ? rd : 32'd0;
    res.timer_irq = 3'(level_status_next | pulse);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_fs       <= TICK_PERIOD_RESET;
      legacy_route_capable <= 1'b1;
      timer_route_mask     <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TICK_PERIOD: tick_period_fs       <= cfg_data[26:0];
        CFG_LEGACY_CAP:  legacy_route_capable <= cfg_data[0];
        CFG_ROUTE_MASK:  timer_route_mask     <= cfg_data;
        default: ;
      endcase
    end
  end

  // timer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      main_count      <= 64'd0;
      global_enable   <= 1'b0;
      legacy_route_on <= 1'b0;
      level_status    <= '0;
      t_level         <= '0;
      t_enable        <= '0;
      for (int n = 0; n < NUM_TIMERS; n++) begin
        t_route[n]       <= 5'd0;
        compare_value[n] <= '1;
      end
    end else if (accept) begin
      main_count      <= main_count_next;
      global_enable   <= global_enable_next;
      legacy_route_on <= legacy_route_on_next;
      level_status    <= level_status_next;
      t_level         <= t_level_next;
      t_enable        <= t_enable_next;
      t_route         <= t_route_next;
      compare_value   <= compare_value_next;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else if (!accept) begin
          out_valid <= 1'b0;
        end
      end
      if (accept) begin
        if (out_valid && !take) begin
          skid_data  <= res;
          skid_valid <= 1'b1;
        end else begin
          out_data  <= res;
          out_valid <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // skid only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // halted counter does not move on a tick
  a_halt_holds_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.command == CMD_TICK) && !global_enable) |=> $stable(main_count))
    else $error("main counter moved while halted");

  // status only changes with an accepted item
  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(level_status))
    else $error("interrupt status changed without an accepted item");

  // a write into an empty output stage yields zero read data
  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.command == CMD_WRITE) && !out_valid)
      |=> (out_valid && (out_data.read_data == 32'd0)))
    else $error("write produced nonzero read data");
`endif

endmodule

`default_nettype wire

FILE: bench/event_timer_register_block_tb.sv
`timescale 1ns / 100ps

module event_timer_register_block_tb;
  import etrb_pkg::*;

  // command code that the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // register index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item_word = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predicted timer state and settings
  logic [63:0] ctr;
  logic        ctr_run;
  logic        legacy_on;
  logic [2:0]  irq_status;
  logic [6:0]  tmr_cfg [NUM_TIMERS];
  logic [63:0] tmr_cmp [NUM_TIMERS];
  logic [26:0] period_fs;
  logic        legacy_cap;
  logic [31:0] route_mask;

  result_t pending_results [$];
  result_t oldest;
  int      errors = 0;
  int      stall_left = 0;
  bit      quiet = 1'b0;

  event_timer_register_block i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [9:0] timer_word(int n, logic [2:0] sub);
    return {W_TMR_PAGE, 3'(n), sub};
  endfunction

  // state after reset
  function automatic void timer_reset();
    ctr        = '0;
    ctr_run    = 1'b0;
    legacy_on  = 1'b0;
    irq_status = '0;
    period_fs  = TICK_PERIOD_RESET;
    legacy_cap = 1'b1;
    route_mask = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      tmr_cfg[t] = '0;
      tmr_cmp[t] = '1;
    end
  endfunction

  // apply one word to the predicted state and return its result
  function automatic result_t timer_step(item_t w);
    result_t     r;
    logic [2:0]  pulse;
    logic [2:0]  n;
    logic [2:0]  sub;
    logic [31:0] d;
    bit          is_tmr;
    r      = '0;
    pulse  = '0;
    d      = w.write_data;
    n      = w.word_index[5:3];
    sub    = w.word_index[2:0];
    is_tmr = (w.word_index[9:6] == W_TMR_PAGE) && (n < NUM_TIMERS);
    case (w.command)
      CMD_TICK: begin
        if (ctr_run) begin
          ctr = ctr + 64'd1;
          for (int t = 0; t < NUM_TIMERS; t++) begin
            if (tmr_cmp[t] == ctr && tmr_cfg[t][1]) begin
              if (tmr_cfg[t][0]) begin
                irq_status[t] = 1'b1;
              end else begin
                pulse[t] = 1'b1;
              end
            end
          end
        end
      end
      CMD_READ: begin
        if (is_tmr) begin
          case (sub)
            SUB_CONF: r.read_data = 32'({tmr_cfg[n][6:2], 3'b000, 1'b1, 2'b00,
                                         tmr_cfg[n][1], tmr_cfg[n][0], 1'b0});
            SUB_ROUTE:  r.read_data = route_mask;
            SUB_CMP_LO: r.read_data = tmr_cmp[n][31:0];
            SUB_CMP_HI: r.read_data = tmr_cmp[n][63:32];
            default:    r.read_data = '0;
          endcase
        end else begin
          case (w.word_index)
            W_CAP_LO: r.read_data = {16'h0000, legacy_cap, 1'b0, 1'b1,
                                     5'(NUM_TIMERS - 1), CAP_REVISION};
            W_CAP_HI: r.read_data = 32'(period_fs);
            W_CFG_LO: r.read_data = {30'd0, legacy_on, ctr_run};
            W_ISR_LO: r.read_data = 32'(irq_status);
            W_CNT_LO: r.read_data = ctr[31:0];
            W_CNT_HI: r.read_data = ctr[63:32];
            default:  r.read_data = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        if (is_tmr) begin
          case (sub)
            SUB_CONF:   tmr_cfg[n] = {d[13:9], d[2], d[1]};
            SUB_CMP_LO: tmr_cmp[n][31:0] = d;
            SUB_CMP_HI: tmr_cmp[n][63:32] = d;
            default: ;
          endcase
        end else begin
          case (w.word_index)
            W_CFG_LO: begin
              ctr_run   = d[0];
              legacy_on = d[1];
            end
            W_ISR_LO: irq_status = irq_status & ~d[2:0];
            W_CNT_LO: ctr[31:0] = d;
            W_CNT_HI: ctr[63:32] = d;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    r.timer_irq = irq_status | pulse;
    return r;
  endfunction

  // send one word and record what it should produce
  task automatic issue_word(item_t w);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_word  <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(timer_step(w));
  endtask

  task automatic access(logic [1:0] cmd, logic [9:0] word, logic [31:0] data);
    item_t w;
    w.command    = cmd;
    w.word_index = word;
    w.write_data = data;
    issue_word(w);
  endtask

  // stop sending and wait for every expected word
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write the three settings back to back, optionally the spare index too
  task automatic write_setting(logic [31:0] period_word, logic [31:0] cap_word,
                               logic [31:0] mask_word, bit with_spare);
    logic [1:0]  idx [4];
    logic [31:0] val [4];
    int          count;
    idx[0] = CFG_TICK_PERIOD; val[0] = period_word;
    idx[1] = CFG_LEGACY_CAP;  val[1] = cap_word;
    idx[2] = CFG_ROUTE_MASK;  val[2] = mask_word;
    idx[3] = CFG_SPARE;       val[3] = $urandom;
    count = with_spare ? 4 : 3;
    for (int k = 0; k < count; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[k])
        CFG_TICK_PERIOD: period_fs = val[k][26:0];
        CFG_LEGACY_CAP:  legacy_cap = val[k][0];
        CFG_ROUTE_MASK:  route_mask = val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // random word, biased toward mapped registers and comparator hits
  function automatic item_t random_item();
    item_t      w;
    int         r;
    logic [2:0] n;
    logic [2:0] sub;
    w.command    = CMD_TICK;
    w.word_index = 10'($urandom);
    w.write_data = $urandom;
    r = $urandom_range(0, 99);
    if (r >= 40 && r < 45) begin
      w.command = CMD_UNUSED;
    end else if (r >= 45) begin
      w.command = (r < 70) ? CMD_READ : CMD_WRITE;
      case ($urandom_range(0, 9))
        0: w.word_index = W_CFG_LO;
        1: w.word_index = W_ISR_LO;
        2: w.word_index = $urandom_range(0, 1) ? W_CNT_LO : W_CNT_HI;
        3: w.word_index = $urandom_range(0, 1) ? W_CAP_LO : W_CAP_HI;
        4, 5, 6, 7: w.word_index = timer_word($urandom_range(0, NUM_TIMERS - 1),
                                              3'($urandom_range(0, 3)));
        8: w.word_index = timer_word($urandom_range(0, 7), 3'($urandom_range(0, 7)));
        default: ;
      endcase
      if (w.command == CMD_WRITE) begin
        n   = w.word_index[5:3];
        sub = w.word_index[2:0];
        if (w.word_index == W_CFG_LO) begin
          w.write_data[0] = ($urandom_range(0, 9) != 0);
        end else if (w.word_index == W_CNT_LO && $urandom_range(0, 3) == 0) begin
          w.write_data = 32'hFFFF_FFFF - $urandom_range(0, 6);
        end else if (w.word_index == W_CNT_HI && $urandom_range(0, 3) == 0) begin
          w.write_data = 32'hFFFF_FFFF;
        end else if (w.word_index[9:6] == W_TMR_PAGE && n < NUM_TIMERS &&
                     $urandom_range(0, 4) != 0) begin
          // aim the comparator just ahead of the counter
          if (sub == SUB_CMP_LO) begin
            w.write_data = ctr[31:0] + $urandom_range(1, 12);
          end else if (sub == SUB_CMP_HI) begin
            w.write_data = ctr[63:32];
          end
        end
      end
    end
    return w;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, result_word);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (result_word.read_data !== oldest.read_data) begin
          $display("%0t read_data mismatch: expected %h actual %h",
                   $time, oldest.read_data, result_word.read_data);
          errors++;
        end
        if (result_word.timer_irq !== oldest.timer_irq) begin
          $display("%0t timer_irq mismatch: expected %b actual %b",
                   $time, oldest.timer_irq, result_word.timer_irq);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = pick_gap() - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // reset values, read-only and unmapped words, unused command
  task automatic test_register_map();
    access(CMD_READ, W_CAP_LO, '0);
    access(CMD_READ, W_CAP_HI, '0);
    access(CMD_READ, timer_word(0, SUB_CMP_HI), '0);
    access(CMD_READ, timer_word(0, SUB_ROUTE), '0);
    access(CMD_READ, 10'h3FF, '0);
    access(CMD_READ, timer_word(NUM_TIMERS, SUB_CONF), '0);
    access(CMD_WRITE, W_CAP_HI, 32'hFFFF_FFFF);
    access(CMD_READ, W_CAP_HI, '0);
    access(CMD_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
  endtask

  // counter wrap, level and edge matches, disabled timer, halted counter
  task automatic test_counter_wrap_and_match();
    access(CMD_WRITE, W_CNT_LO, 32'hFFFF_FFFE);
    access(CMD_WRITE, W_CNT_HI, 32'hFFFF_FFFF);
    access(CMD_WRITE, timer_word(0, SUB_CONF), 32'h0000_3E06);
    access(CMD_WRITE, timer_word(1, SUB_CONF), 32'h0000_0004);
    access(CMD_WRITE, timer_word(1, SUB_CMP_LO), '0);
    access(CMD_WRITE, timer_word(1, SUB_CMP_HI), '0);
    access(CMD_WRITE, timer_word(2, SUB_CMP_LO), '0);
    access(CMD_WRITE, timer_word(2, SUB_CMP_HI), '0);
    access(CMD_WRITE, W_CFG_LO, 32'h0000_0003);
    access(CMD_TICK, '0, '0);
    access(CMD_TICK, '0, '0);
    access(CMD_READ, W_CFG_LO, '0);
    access(CMD_READ, timer_word(0, SUB_CONF), '0);
    access(CMD_WRITE, W_CFG_LO, '0);
    access(CMD_TICK, '0, '0);
    access(CMD_READ, W_ISR_LO, '0);
    access(CMD_WRITE, W_ISR_LO, 32'hFFFF_FFFF);
    access(CMD_READ, W_CNT_LO, '0);
  endtask

  // lowest and highest settings, seen through the capability and route words
  task automatic test_setting_extremes();
    settle();
    write_setting(32'd1, 32'd0, 32'd0, 1'b1);
    access(CMD_READ, W_CAP_LO, '0);
    access(CMD_READ, W_CAP_HI, '0);
    access(CMD_READ, timer_word(NUM_TIMERS - 1, SUB_ROUTE), '0);
    settle();
    write_setting({5'h1F, 27'd100000000}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    access(CMD_READ, W_CAP_LO, '0);
    access(CMD_READ, W_CAP_HI, '0);
    access(CMD_READ, timer_word(NUM_TIMERS - 1, SUB_ROUTE), '0);
  endtask

  // random traffic in phases, new settings between phases
  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      settle();
      if (p > 0) begin
        write_setting({5'($urandom), 27'($urandom_range(1, 100000000))},
                      $urandom, (p == 3) ? 32'd0 : $urandom, p == 4);
      end
      quiet = (p == 2);
      repeat (125) issue_word(random_item());
    end
    quiet = 1'b0;
  endtask

  // main sequence
  initial begin
    timer_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_register_map();
    test_counter_wrap_and_match();
    test_setting_extremes();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: event_timer_register_block.f
design/etrb_pkg.sv
design/event_timer_register_block.sv
bench/event_timer_register_block_tb.sv
